// File: rtl/dbp_pkg.sv
// types and constants for the dead block replacement engine
`default_nettype none
package dbp_pkg;
  localparam int unsigned NumCfg = 3;
  localparam logic [1:0] CfgPolicy = 2'd0;
  localparam logic [1:0] CfgThresh = 2'd1;
  localparam logic [1:0] CfgCmax = 2'd2;
  localparam logic CmdVictim = 1'b0;
  localparam logic [1:0] KindWb = 2'd1;
  localparam logic [1:0] KindPf = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  set_index;
    logic [3:0]  way_index;
    logic [11:0] pc_signature;
    logic [11:0] line_tag_low;
    logic [1:0]  access_kind;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       bypass;
  } rsp_t;
endpackage
`default_nettype wire

// File: rtl/dead_block_predict_replacement.sv
// dead block replacement engine: lru stacks, dead flags, predictor and sampler
`default_nettype none
// Cache replacement engine. A word is taken when start_i is high and busy_o low.
// After reset a clearing pass over the larger of SETS and 2**SIG_BITS indices (set rows,
// predictor counters and sampler rows in the same sweep) keeps busy_o high. Each item is
// then handled by a sequencer that walks the ways of the addressed set through one
// shared compare and update unit, one way per cycle. A victim request passes through
// StRd, StScan and StVic; an update through StRd, StScan, StUpd and StWr, and an update
// on a sampled set in dead block mode (not a writeback or prefetch, way below WAYS) then
// also through StSRd, StSScan, StSFix and StSWr (lru walk, then sampler search). The
// victim is shown on rsp_o with rsp_valid_o for one cycle, the same cycle in which
// busy_o falls; the receiver cannot stall, so none is held back.
module dead_block_predict_replacement #(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 16,
  parameter int unsigned SIG_BITS = 12,
  parameter int unsigned SAMPLE_SPACING = 32,
  parameter int unsigned COUNTER_BITS = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire dbp_pkg::req_t req_i,
  output logic               busy_o,
  output logic               rsp_valid_o,
  output dbp_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i
);
  localparam int unsigned SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WB = $clog2(WAYS);
  localparam int unsigned SS = (SETS + SAMPLE_SPACING - 1) / SAMPLE_SPACING;
  localparam int unsigned SSB = (SS > 1) ? $clog2(SS) : 1;
  localparam int unsigned PB = SIG_BITS;
  localparam int unsigned NCtr = 2**PB;
  localparam int unsigned ClrLen = (SETS > NCtr) ? SETS : NCtr;
  localparam int unsigned CLB = $clog2(ClrLen);
  localparam logic [COUNTER_BITS-1:0] CtrLim = {COUNTER_BITS{1'b1}};

  typedef enum logic [10:0] {
    StClr = 11'b00000000001, StIdle = 11'b00000000010, StRd = 11'b00000000100,
    StScan = 11'b00000001000, StVic = 11'b00000010000, StUpd = 11'b00000100000,
    StWr = 11'b00001000000, StSRd = 11'b00010000000, StSScan = 11'b00100000000,
    StSFix = 11'b01000000000, StSWr = 11'b10000000000
  } st_e;

  st_e st_q, st_d;
  logic policy_q; logic [1:0] thr_q, cmax_q;
  dbp_pkg::req_t r_q;
  logic [SB-1:0] set_q;
  logic [CLB-1:0] clr_q;
  logic [WB:0] w_q;

  // set rows: lru positions and dead flags
  logic [WAYS*WB-1:0] lru_mem [SETS];
  logic [WAYS-1:0] dead_mem [SETS];
  logic [COUNTER_BITS-1:0] ctr_mem [NCtr];
  logic [WAYS*PB-1:0] stag_mem [SS];
  logic [WAYS*PB-1:0] ssig_mem [SS];
  logic [WAYS-1:0] sval_mem [SS];
  logic [WAYS-1:0] sdead_mem [SS];
  logic [WAYS*WB-1:0] slru_mem [SS];

  logic [WAYS*WB-1:0] lru_q, slru_q, ident, lru_n, slru_n;
  logic [WAYS-1:0] dead_q, sval_q, sdead_q, dead_n, sval_n, sdead_n;
  logic [WAYS*PB-1:0] stag_q, ssig_q, stag_n, ssig_n;
  logic [COUNTER_BITS-1:0] ctr_q, ectr_q;
  logic [WB-1:0] lruw_q, pick_q, cur_q;
  logic fnd_q, hit_q, inv_q, dfd_q;
  logic [WB-1:0] invw_q, dw_q, hw_q, slw_q, ssel;
  logic [PB-1:0] sig, tag, esig_q;
  logic [SSB-1:0] sidx;
  logic sampled;
  logic [COUNTER_BITS-1:0] ceil;
  logic [WB-1:0] wi, wsel;
  logic wok, ctr_dead, ctr_up;

  always_comb begin
    for (int i = 0; i < WAYS; i++) ident[i*WB +: WB] = WB'(i);
  end
  assign sig = PB'(r_q.pc_signature);
  assign tag = PB'(r_q.line_tag_low);
  assign sidx = SSB'(set_q / SAMPLE_SPACING);
  assign sampled = (set_q % SAMPLE_SPACING) == 0;
  assign wi = w_q[WB-1:0];
  assign wsel = WB'(r_q.way_index);
  assign wok = 32'(r_q.way_index) < WAYS;
  assign ceil = (32'(cmax_q) < 32'(CtrLim)) ? COUNTER_BITS'(cmax_q) : CtrLim;
  assign ctr_dead = 32'(ctr_q) > 32'(thr_q);
  assign ctr_up = !hit_q && fnd_q && ectr_q < ceil;
  assign ssel = hit_q ? hw_q : inv_q ? invw_q : dfd_q ? dw_q : slw_q;
  assign busy_o = st_q != StIdle;
  assign cfg_ready_o = 1'b1;

  logic side;
  assign side = r_q.access_kind == dbp_pkg::KindWb || r_q.access_kind == dbp_pkg::KindPf;
  logic [SB-1:0] in_set;
  assign in_set = SB'(32'(req_i.set_index) % SETS);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClr:   if (clr_q == CLB'(ClrLen-1)) st_d = StIdle;
      StIdle:  if (start_i) st_d = StRd;
      StRd:    st_d = StScan;
      StScan:  if (w_q == (WB+1)'(WAYS-1))
                 st_d = (r_q.cmd == dbp_pkg::CmdVictim) ? StVic : StUpd;
      StVic:   st_d = StIdle;
      StUpd:   st_d = StWr;
      StWr:    st_d = (policy_q && !side && sampled && wok) ? StSRd : StIdle;
      StSRd:   st_d = StSScan;
      StSScan: if (w_q == (WB+1)'(WAYS-1)) st_d = StSFix;
      StSFix:  st_d = StSWr;
      StSWr:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic [WB-1:0] p;
  logic [WB-1:0] sp;
  assign p = lru_q[wi*WB +: WB];
  assign sp = slru_q[wi*WB +: WB];

  // set row after the move to mru, with the new dead flag
  always_comb begin
    lru_n = lru_q;
    for (int i = 0; i < WAYS; i++)
      if (lru_q[i*WB +: WB] < cur_q) lru_n[i*WB +: WB] = lru_q[i*WB +: WB] + WB'(1);
    lru_n[wsel*WB +: WB] = '0;
    dead_n = dead_q;
    dead_n[wsel] = ctr_dead;
  end

  // sampler row after a hit or a fill
  always_comb begin
    slru_n = slru_q;
    for (int i = 0; i < WAYS; i++)
      if (slru_q[i*WB +: WB] < slru_q[pick_q*WB +: WB])
        slru_n[i*WB +: WB] = slru_q[i*WB +: WB] + WB'(1);
    slru_n[pick_q*WB +: WB] = '0;
    ssig_n = ssig_q;
    ssig_n[pick_q*PB +: PB] = sig;
    stag_n = stag_q;
    sval_n = sval_q;
    sdead_n = sdead_q;
    if (hit_q) begin
      sdead_n[pick_q] = 1'b0;
    end else begin
      stag_n[pick_q*PB +: PB] = tag;
      sval_n[pick_q] = 1'b1;
      // prediction seen after the evicted entry's increment
      sdead_n[pick_q] = (32'(ctr_q) + ((ctr_up && esig_q == sig) ? 32'd1 : 32'd0))
                        > 32'(thr_q);
    end
  end

  // control registers: state, configuration, clear and way counters, response strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; policy_q <= 1'b1; thr_q <= 2'd2; cmax_q <= 2'd3;
      rsp_valid_o <= 1'b0; w_q <= '0;
    end else begin
      st_q <= st_d;
      rsp_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dbp_pkg::CfgPolicy: policy_q <= cfg_data_i[0];
          dbp_pkg::CfgThresh: thr_q <= cfg_data_i[1:0];
          dbp_pkg::CfgCmax:   cmax_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (st_q == StClr) clr_q <= clr_q + CLB'(1);
      if (st_q == StRd || st_q == StSRd || st_q == StIdle) w_q <= '0;
      else if (st_q == StScan || st_q == StSScan) w_q <= w_q + (WB+1)'(1);
      if (st_q == StVic) rsp_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StClr: begin
        if (32'(clr_q) < SETS) begin
          lru_mem[SB'(clr_q)] <= ident; dead_mem[SB'(clr_q)] <= '0;
        end
        if (32'(clr_q) < NCtr) ctr_mem[PB'(clr_q)] <= '0;
        if (32'(clr_q) < SS) begin
          ssig_mem[SSB'(clr_q)] <= '0; sval_mem[SSB'(clr_q)] <= '0;
          sdead_mem[SSB'(clr_q)] <= '0; slru_mem[SSB'(clr_q)] <= ident;
          stag_mem[SSB'(clr_q)] <= '0;
        end
      end
      StIdle: if (start_i) begin r_q <= req_i; set_q <= in_set; end
      StRd: begin
        lru_q <= lru_mem[set_q]; dead_q <= dead_mem[set_q];
        ctr_q <= ctr_mem[sig]; fnd_q <= 1'b0; lruw_q <= '0; pick_q <= '0;
        cur_q <= '0;
      end
      StScan: begin
        if (p == WB'(WAYS-1)) lruw_q <= wi;
        if (dead_q[wi] && !fnd_q) begin fnd_q <= 1'b1; pick_q <= wi; end
        if (wi == wsel) cur_q <= p;
      end
      StVic: begin
        rsp_o.bypass <= policy_q && (ctr_dead || side);
        if (!policy_q) rsp_o.victim_way <= 4'(lruw_q);
        else if (ctr_dead || side) rsp_o.victim_way <= '0;
        else rsp_o.victim_way <= fnd_q ? 4'(pick_q) : 4'(lruw_q);
      end
      StUpd: begin
        lru_q <= lru_n;
        dead_q <= dead_n;
      end
      StWr: if (wok && !(policy_q && side)) begin
        lru_mem[set_q] <= lru_q;
        if (policy_q) dead_mem[set_q] <= dead_q;
      end
      StSRd: begin
        stag_q <= stag_mem[sidx]; ssig_q <= ssig_mem[sidx]; sval_q <= sval_mem[sidx];
        sdead_q <= sdead_mem[sidx]; slru_q <= slru_mem[sidx];
        hit_q <= 1'b0; inv_q <= 1'b0; dfd_q <= 1'b0; hw_q <= '0; invw_q <= '0;
        dw_q <= '0; slw_q <= '0;
      end
      StSScan: begin
        if (sval_q[wi] && stag_q[wi*PB +: PB] == tag && !hit_q) begin
          hit_q <= 1'b1; hw_q <= wi;
        end
        if (!sval_q[wi] && !inv_q) begin inv_q <= 1'b1; invw_q <= wi; end
        if (sdead_q[wi] && !dfd_q) begin dfd_q <= 1'b1; dw_q <= wi; end
        if (sp == WB'(WAYS-1)) slw_q <= wi;
      end
      StSFix: begin
        pick_q <= ssel;
        esig_q <= ssig_q[ssel*PB +: PB];
        ectr_q <= ctr_mem[ssig_q[ssel*PB +: PB]];
        fnd_q <= !hit_q && !inv_q && sval_q[ssel];
      end
      StSWr: begin
        slru_mem[sidx] <= slru_n;
        ssig_mem[sidx] <= ssig_n;
        stag_mem[sidx] <= stag_n; sval_mem[sidx] <= sval_n; sdead_mem[sidx] <= sdead_n;
        if (hit_q) begin
          if (ctr_q != '0) ctr_mem[sig] <= ctr_q - COUNTER_BITS'(1);
        end else if (ctr_up) begin
          ctr_mem[esig_q] <= ectr_q + COUNTER_BITS'(1);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
